>>> hw/rtl/frc_pkg.sv
// Shared types and constants for the frame receive checker.
// No dependencies.
`default_nettype none
package frc_pkg;

  localparam int unsigned HeaderBytes = 60;
  localparam logic [31:0] CrcPoly     = 32'h82F63B78;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PROTOCOL  = 3'd1,
    ST_VERSION   = 3'd2,
    ST_OVERSIZED = 3'd3,
    ST_CRC       = 3'd4
  } status_t;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_BODY   = 1'b1;

  localparam logic [1:0] REG_MAGIC   = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_MAXLEN  = 2'd2;

  localparam logic [15:0] TypeLowMax  = 16'd4;
  localparam logic [15:0] TypeHighMin = 16'd10;
  localparam logic [15:0] TypeHighMax = 16'd41;

  // One result item as it travels through the queue
  typedef struct packed {
    logic        item_kind;
    logic [2:0]  status;
    logic [15:0] message_type;
    logic [31:0] flags_word;
    logic [63:0] session_high;
    logic [63:0] session_low;
    logic [63:0] epoch_value;
    logic [63:0] sequence_number;
    logic [63:0] correlation_id;
    logic [31:0] declared_length;
    logic [7:0]  body_byte;
    logic        frame_end;
  } result_t;

  // Advance a reflected CRC-32C by one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/frc_front.sv
// Front part: collects header bytes, checks the header, runs CRC on body bytes.
// Depends on frc_pkg.
`default_nettype none
module frc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [7:0]      in_byte,
  input  wire logic [31:0]     frame_magic,
  input  wire logic [15:0]     local_version,
  input  wire logic [31:0]     max_body_length,
  output logic                 res_valid,
  output frc_pkg::result_t     res
);

  logic [479:0] header_store;
  logic [5:0]   header_count;
  logic         in_body;
  logic [31:0]  bytes_left;
  logic [31:0]  running_crc;
  logic [31:0]  expected_crc;

  logic [479:0] hdr;
  logic [31:0]  magic, blen, ecrc;
  logic [15:0]  ver, mtype;
  logic         type_ok;
  logic [2:0]   hstatus;
  logic [31:0]  crc_next;
  logic         last_hdr;
  frc_pkg::result_t res_next;

  // Assemble the full header including the byte arriving now
  always_comb begin
    hdr = header_store;
    hdr[479 -: 8] = in_byte;
    magic = hdr[31:0];
    ver   = hdr[47:32];
    mtype = hdr[63:48];
    blen  = hdr[447:416];
    ecrc  = hdr[479:448];
    type_ok = (mtype >= 16'd1 && mtype <= frc_pkg::TypeLowMax) ||
              (mtype >= frc_pkg::TypeHighMin && mtype <= frc_pkg::TypeHighMax);
    if (magic != frame_magic)           hstatus = frc_pkg::ST_PROTOCOL;
    else if (ver != local_version)      hstatus = frc_pkg::ST_VERSION;
    else if (!type_ok)                  hstatus = frc_pkg::ST_PROTOCOL;
    else if (blen > max_body_length)    hstatus = frc_pkg::ST_OVERSIZED;
    else if (blen == 32'd0 && ecrc != 32'd0) hstatus = frc_pkg::ST_CRC;
    else                                hstatus = frc_pkg::ST_OK;
    crc_next = frc_pkg::crc_byte(running_crc, in_byte);
    last_hdr = (header_count == 6'(frc_pkg::HeaderBytes - 1));
  end

  // Build the result beat for the byte arriving now
  always_comb begin
    res_next = '0;
    if (in_body) begin
      res_next.item_kind = frc_pkg::KIND_BODY;
      res_next.body_byte = in_byte;
      if (bytes_left == 32'd1) begin
        res_next.status    = ((~crc_next) == expected_crc) ? frc_pkg::ST_OK
                                                           : frc_pkg::ST_CRC;
        res_next.frame_end = 1'b1;
      end
    end else begin
      res_next.item_kind       = frc_pkg::KIND_HEADER;
      res_next.status          = hstatus;
      res_next.message_type    = mtype;
      res_next.flags_word      = hdr[95:64];
      res_next.session_high    = hdr[159:96];
      res_next.session_low     = hdr[223:160];
      res_next.epoch_value     = hdr[287:224];
      res_next.sequence_number = hdr[351:288];
      res_next.correlation_id  = hdr[415:352];
      res_next.declared_length = blen;
      res_next.frame_end       = (hstatus != frc_pkg::ST_OK) || (blen == 32'd0);
    end
  end

  // Advance frame state and register one result per body byte and one for the last header byte
  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
      in_body      <= 1'b0;
      bytes_left   <= '0;
      running_crc  <= '1;
      expected_crc <= '0;
      res_valid    <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      if (in_valid) begin
        res <= res_next;
        if (in_body) begin
          running_crc <= crc_next;
          bytes_left  <= bytes_left - 32'd1;
          res_valid   <= 1'b1;
          if (bytes_left == 32'd1) begin
            in_body <= 1'b0;
          end
        end else begin
          header_store[header_count*8 +: 8] <= in_byte;
          if (!last_hdr) begin
            header_count <= header_count + 6'd1;
          end else begin
            header_count <= '0;
            res_valid    <= 1'b1;
            if (hstatus == frc_pkg::ST_OK || hstatus == frc_pkg::ST_CRC) begin
              expected_crc <= ecrc;
            end
            if (hstatus == frc_pkg::ST_OK && blen != 32'd0) begin
              in_body     <= 1'b1;
              bytes_left  <= blen;
              running_crc <= '1;
            end
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/frc_queue.sv
// Result queue between the front part and the output side.
// Depends on frc_pkg.
`default_nettype none
module frc_queue #(
  parameter int unsigned DEPTH_LOG2 = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire frc_pkg::result_t wr_data,
  output logic [DEPTH_LOG2:0]   count,
  input  wire logic             rd_en,
  output frc_pkg::result_t      rd_data,
  output logic                  empty
);

  localparam int unsigned Depth = 1 << DEPTH_LOG2;

  frc_pkg::result_t mem [Depth];
  logic [DEPTH_LOG2-1:0] wr_ptr, rd_ptr;

  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Store beats and move pointers
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (DEPTH_LOG2+1)'(wr_en) - (DEPTH_LOG2+1)'(rd_en);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/frame_receive_checker.sv
// Frame receive checker top level: config registers, front part, result queue.
// Depends on frc_pkg, frc_front, frc_queue.
// Latency: a result passes through the front result register and then the queue before it is poppable.
// Throughput: one byte per cycle while full is low; the CRC step is one byte-wide update per cycle.
// full rises when the queue cannot absorb the byte in flight plus a new one.
// Reset (synchronous rst): expect a header, clear queue and registers.
`default_nettype none
module frame_receive_checker #(
  parameter int unsigned QUEUE_LOG2 = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  stream_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic             item_kind,
  output logic [2:0]       status,
  output logic [15:0]      message_type,
  output logic [31:0]      flags_word,
  output logic [63:0]      session_high,
  output logic [63:0]      session_low,
  output logic [63:0]      epoch_value,
  output logic [63:0]      sequence_number,
  output logic [63:0]      correlation_id,
  output logic [31:0]      declared_length,
  output logic [7:0]       body_byte,
  output logic             frame_end
);

  localparam int unsigned Depth = 1 << QUEUE_LOG2;

  logic [31:0] frame_magic, max_body_length;
  logic [15:0] local_version;
  logic        accept, deq, res_valid;
  logic [QUEUE_LOG2:0] count;
  frc_pkg::result_t res, head;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign accept  = push && !full;
  assign deq     = pop && !empty;
  // Leave room for the result still in the front register
  assign full    = (count + (QUEUE_LOG2+1)'(res_valid)) >= (QUEUE_LOG2+1)'(Depth);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_magic     <= '0;
      local_version   <= '0;
      max_body_length <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        frc_pkg::REG_MAGIC:   frame_magic     <= pwdata;
        frc_pkg::REG_VERSION: local_version   <= pwdata[15:0];
        frc_pkg::REG_MAXLEN:  max_body_length <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (reg_idx)
      frc_pkg::REG_MAGIC:   prdata = frame_magic;
      frc_pkg::REG_VERSION: prdata = {16'd0, local_version};
      frc_pkg::REG_MAXLEN:  prdata = max_body_length;
      default:              prdata = '0;
    endcase
  end

  frc_front u_front (
    .clk, .rst,
    .in_valid(accept), .in_byte(stream_byte),
    .frame_magic, .local_version, .max_body_length,
    .res_valid, .res
  );

  frc_queue #(.DEPTH_LOG2(QUEUE_LOG2)) u_queue (
    .clk, .rst,
    .wr_en(res_valid), .wr_data(res), .count,
    .rd_en(deq), .rd_data(head), .empty
  );

  assign item_kind       = head.item_kind;
  assign status          = head.status;
  assign message_type    = head.message_type;
  assign flags_word      = head.flags_word;
  assign session_high    = head.session_high;
  assign session_low     = head.session_low;
  assign epoch_value     = head.epoch_value;
  assign sequence_number = head.sequence_number;
  assign correlation_id  = head.correlation_id;
  assign declared_length = head.declared_length;
  assign body_byte       = head.body_byte;
  assign frame_end       = head.frame_end;

  // Queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_LOG2+1)'(Depth)) else $error("result queue overflow");
  // A result only follows an accepted byte
  a_res_cause: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(accept)) else $error("result without input byte");
  // Body results never carry oversized or version status
  a_body_status: assert property (@(posedge clk) disable iff (rst)
    (!empty && item_kind == frc_pkg::KIND_BODY) |->
      (status == frc_pkg::ST_OK || status == frc_pkg::ST_CRC))
    else $error("bad body status");

endmodule
`default_nettype wire
